[rtl/core/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

[rtl/core/tmwf_pkg.sv]
package tmwf_pkg;

  // sample format
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned WINDOW_DEF = 10;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // item sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV
  } tmwf_state_e;

endpackage

[rtl/core/tmwf_hist.sv]
// History store: one synchronous read port, one write port.
// Entries never written read as zero (per-entry valid bits).
module tmwf_hist import tmwf_pkg::*; #(
  parameter int unsigned DEPTH = WINDOW_DEF - 1,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output sample_t       rd_data_o,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  sample_t       wr_data_i
);

  sample_t              mem [DEPTH];
  logic    [DEPTH-1:0]  vld_q;
  sample_t              rd_q;
  logic                 rd_vld_q;

  // storage write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // valid bits stand in for the zero-clear at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

[rtl/core/tmwf_div.sv]
// Signed divide by a constant, truncating toward zero.
// Magnitude times a rounded-up reciprocal, then a right shift; exact for
// every ACC_W-bit magnitude. Operands are registered on start and the
// product the cycle after, so busy_o is high for one cycle.
module tmwf_div import tmwf_pkg::*; #(
  parameter int unsigned ACC_W   = SAMPLE_W + $clog2(WINDOW_DEF),
  parameter int unsigned DIVISOR = WINDOW_DEF - 2
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [ACC_W-1:0] dividend_i,
  output logic                    busy_o,
  output sample_t                 quot_o
);

  localparam int unsigned     LG    = $clog2(DIVISOR);
  localparam int unsigned     SH    = ACC_W + LG;
  localparam int unsigned     PW    = SH + ACC_W;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

  logic [ACC_W-1:0] mag;
  logic [ACC_W-1:0] mag_q;
  logic             neg_q;
  logic             busy_q;
  logic [ACC_W:0]   recip;
  logic [PW-1:0]    prod;
  logic [ACC_W-1:0] q_mag_q;
  logic [ACC_W-1:0] q_signed;

  assign mag = dividend_i[ACC_W-1] ? $unsigned(-dividend_i) : $unsigned(dividend_i);

  // busy for the multiply cycle only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= start_i;
    end
  end

  // operand capture, then reciprocal multiply
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= mag;
      neg_q <= dividend_i[ACC_W-1];
    end
    if (busy_q) begin
      q_mag_q <= prod[SH +: ACC_W];
    end
  end

  assign recip    = (ACC_W+1)'(RECIP);
  assign prod     = PW'(mag_q) * PW'(recip);
  assign busy_o   = busy_q;
  assign q_signed = neg_q ? (~q_mag_q + 1'b1) : q_mag_q;
  assign quot_o   = sample_t'(q_signed[SAMPLE_W-1:0]);

endmodule

[rtl/core/trimmed_mean_window_filter_unit.sv]
// Channel   Dir  Handshake               Payload
// s_axis    in   tvalid_i / tready_o     tdata_i[15:0] = sample (signed)
// m_axis    out  tvalid_o / tready_i     tdata_o[15:0] = filtered (signed)
//
// Each word is accepted, then the history memory is swept through its
// single read port and the new sample written back, then the divider
// registers its operands and then the product. Reset is asynchronous,
// active low; history reads as zero until written. A finished result
// waits in the output register while the next word is taken; the divider
// holds its quotient until that register frees up.
`include "assert_macros.svh"

module trimmed_mean_window_filter_unit import tmwf_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [SAMPLE_W-1:0] s_axis_tdata_i,   // [15:0] sample
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [SAMPLE_W-1:0] m_axis_tdata_o    // [15:0] filtered
);

  localparam int unsigned DEPTH   = WINDOW - 1;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned CW      = $clog2(DEPTH + 1);
  localparam int unsigned ACC_W   = SAMPLE_W + $clog2(WINDOW);
  localparam int unsigned DIVISOR = WINDOW - 2;

  tmwf_state_e state_q, state_d;

  logic [CW-1:0] rd_cnt_q;
  logic          rd_pend_q;
  logic [AW-1:0] ptr_q;
  logic          m_valid_q;
  sample_t       filtered_q;

  sample_t                 fresh_q, hi_q, lo_q;
  logic signed [ACC_W-1:0] sum_q;
  logic signed [ACC_W-1:0] total;

  logic    s_accept;
  logic    hist_rd_en, hist_wr_en;
  sample_t hist_rd_data;
  logic    div_start, div_busy;
  sample_t div_quot;
  logic    slot_free, load_out, sweep_done;

  assign s_accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free  = !m_valid_q || m_axis_tready_i;
  assign sweep_done = (rd_cnt_q == CW'(DEPTH)) && !rd_pend_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) state_d = ST_READ;
      end
      ST_READ: begin
        if (sweep_done) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy && slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    hist_rd_en      = 1'b0;
    hist_wr_en      = 1'b0;
    div_start       = 1'b0;
    load_out        = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready_o = 1'b1;
      ST_READ: begin
        hist_rd_en = (rd_cnt_q != CW'(DEPTH));
        hist_wr_en = sweep_done;
        div_start  = sweep_done;
      end
      ST_DIV:  load_out = !div_busy && slot_free;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_cnt_q  <= '0;
      rd_pend_q <= 1'b0;
      ptr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= hist_rd_en;
      if (s_accept) begin
        rd_cnt_q <= '0;
      end else if (hist_rd_en) begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
      end
      // oldest entry is replaced, pointer wraps at DEPTH
      if (hist_wr_en) begin
        ptr_q <= (ptr_q == AW'(DEPTH - 1)) ? '0 : ptr_q + 1'b1;
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // sum, max and min over the window; output result register
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      fresh_q <= sample_t'(s_axis_tdata_i);
      hi_q    <= sample_t'(s_axis_tdata_i);
      lo_q    <= sample_t'(s_axis_tdata_i);
      sum_q   <= ACC_W'(sample_t'(s_axis_tdata_i));
    end else if (rd_pend_q) begin
      sum_q <= sum_q + ACC_W'(hist_rd_data);
      if (hist_rd_data > hi_q) hi_q <= hist_rd_data;
      if (hist_rd_data < lo_q) lo_q <= hist_rd_data;
    end
    if (load_out) begin
      filtered_q <= div_quot;
    end
  end

  // drop one largest and one smallest
  assign total = sum_q - ACC_W'(hi_q) - ACC_W'(lo_q);

  tmwf_hist #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_hist (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (hist_rd_en),
    .rd_addr_i (rd_cnt_q[AW-1:0]),
    .rd_data_o (hist_rd_data),
    .wr_en_i   (hist_wr_en),
    .wr_addr_i (ptr_q),
    .wr_data_i (fresh_q)
  );

  tmwf_div #(
    .ACC_W   (ACC_W),
    .DIVISOR (DIVISOR)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (total),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = filtered_q;

  // checks
  `ASSERT_PROP(a_div_start_idle, clk_i, rst_ni, div_start |-> !div_busy, "divider restarted while busy")
  `ASSERT_NEVER(a_rd_cnt_range, clk_i, rst_ni, rd_cnt_q > CW'(DEPTH), "history sweep overran")
  `ASSERT_NEVER(a_wr_rd_overlap, clk_i, rst_ni, hist_wr_en && (hist_rd_en || rd_pend_q), "write-back overlaps sweep")
  `ASSERT_PROP(a_load_shows, clk_i, rst_ni, load_out |=> m_valid_q && (m_axis_tdata_o == $past(div_quot)), "quotient not presented")

endmodule

[dv/trimmed_mean_window_filter_unit_test.sv]
`timescale 1ns / 1ps

module trimmed_mean_window_filter_unit_test;
  import tmwf_pkg::*;

  localparam int unsigned WIN          = WINDOW_DEF;
  localparam int unsigned HIST_DEPTH   = WIN - 1;
  localparam int          RANDOM_ITEMS = 1750;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          REPORT_MAX   = 10;
  // allow several word times at the end
  localparam int          SETTLE_CYCLES = 4 * (WIN + 16);

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [SAMPLE_W-1:0] s_axis_tdata_i;   // [15:0] sample
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [SAMPLE_W-1:0] m_axis_tdata_o;   // [15:0] filtered

  // no idling on either side while set
  bit quiet_phase;
  int cycle_count;

  // Tracks the sample window and holds the trimmed means still owed by the block
  class mean_tracker;
    sample_t history[HIST_DEPTH];
    sample_t pending_means[$];
    int      errors;

    function new();
      foreach (history[k]) history[k] = '0;
      errors = 0;
    endfunction

    // sum of window, minus one largest and one smallest, divided by WIN - 2, truncated toward zero
    function sample_t trimmed_mean(sample_t fresh);
      longint hi;
      longint lo;
      longint total;
      longint divisor;
      hi      = fresh;
      lo      = fresh;
      total   = fresh;
      divisor = longint'(WIN) - 2;
      foreach (history[k]) begin
        if (history[k] > hi) hi = history[k];
        if (history[k] < lo) lo = history[k];
        total += history[k];
      end
      total = total - hi - lo;
      return sample_t'(total / divisor);
    endfunction

    // accepted sample word: predict, then shift the window
    function void note_sample(sample_t fresh);
      pending_means.push_back(trimmed_mean(fresh));
      for (int k = HIST_DEPTH - 1; k > 0; k--) history[k] = history[k - 1];
      history[0] = fresh;
    endfunction

    // accepted result word
    function void check_filtered(sample_t got);
      sample_t want;
      if (pending_means.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("[%0t] unexpected filtered word %0d", $time, got);
      end else begin
        want = pending_means.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("[%0t] filtered mismatch: expected %0d, got %0d", $time, want, got);
        end
      end
    endfunction
  endclass

  mean_tracker tracker;

  trimmed_mean_window_filter_unit #(
    .WINDOW(WIN)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // random samples: full range, extremes, small steps, repeats, near zero
  function automatic sample_t random_sample(sample_t prev);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      v = $urandom();
    end else if (r < 50) begin
      case ($urandom_range(0, 3))
        0:       v = 32767;
        1:       v = -32768;
        2:       v = 32766;
        default: v = -32767;
      endcase
    end else if (r < 75) begin
      v = int'(prev) + int'($urandom_range(0, 64)) - 32;
    end else if (r < 90) begin
      v = prev;
    end else begin
      v = int'($urandom_range(0, 15)) - 8;
    end
    return sample_t'(v);
  endfunction

  // one sample word onto the input stream; optionally hold off until drained
  task automatic send_sample(sample_t s, bit drain_first);
    int gap;
    gap = pick_gap();
    if (drain_first && gap == 0) gap = 1;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      if (drain_first) begin
        while (tracker.pending_means.size() != 0) @(posedge clk_i);
      end
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= s;
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.note_sample(s);
  endtask

  // result side: random back-pressure, check each accepted word
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) tracker.check_filtered(m_axis_tdata_o);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (!quiet_phase && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  // main sequence
  initial begin
    sample_t directed[] = '{
      16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd0, -16'sd1, 16'sd1,
      16'sd21845, -16'sd21846,
      -16'sd7, -16'sd7, -16'sd7, -16'sd7, -16'sd7,
      -16'sd7, -16'sd7, -16'sd7, -16'sd7, -16'sd7,
      16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768
    };
    sample_t prev;

    tracker         = new();
    quiet_phase     = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // extremes, ties, all equal, start-up zeros in the window
    foreach (directed[i]) send_sample(directed[i], 1'b0);

    prev = '0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet_phase = ((i / 128) % 5) == 4;
      prev = random_sample(prev);
      send_sample(prev, i == 0 || i == RANDOM_ITEMS / 2);
    end
    s_axis_tvalid_i <= 1'b0;
    quiet_phase = 1'b0;

    while (tracker.pending_means.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (tracker.errors == 0 && tracker.pending_means.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/tmwf_pkg.sv
rtl/core/tmwf_hist.sv
rtl/core/tmwf_div.sv
rtl/core/trimmed_mean_window_filter_unit.sv
dv/trimmed_mean_window_filter_unit_test.sv
